@@ hdl/cpl_pkg.sv @@
// Shared types and constants for the closest-points-between-lines block.
package cpl_pkg;

    localparam int CW        = 32;   // coordinate width, signed fixed point
    localparam int DIST_W    = 48;   // squared distance width, unsigned
    localparam int FRAC_DEF  = 16;   // default fraction bits
    localparam int LIMB_W    = 32;   // multiplier limb width
    localparam int Q_DEPTH   = 4;    // front/back queue depth
    localparam int MUL_LAT   = 4;    // wide multiplier latency
    localparam int DIV_LAT   = CW + 4;

    typedef struct packed {
        logic signed [CW-1:0] line1_origin_x;
        logic signed [CW-1:0] line1_origin_y;
        logic signed [CW-1:0] line1_origin_z;
        logic signed [CW-1:0] line1_dir_x;
        logic signed [CW-1:0] line1_dir_y;
        logic signed [CW-1:0] line1_dir_z;
        logic signed [CW-1:0] line2_origin_x;
        logic signed [CW-1:0] line2_origin_y;
        logic signed [CW-1:0] line2_origin_z;
        logic signed [CW-1:0] line2_dir_x;
        logic signed [CW-1:0] line2_dir_y;
        logic signed [CW-1:0] line2_dir_z;
    } t_in;

    typedef struct packed {
        logic signed [CW-1:0] param_one;
        logic signed [CW-1:0] param_two;
        logic [DIST_W-1:0]    dist_squared;
    } t_out;

    // queue entry: both directions and the origin difference
    typedef struct packed {
        logic [2:0][CW-1:0] d1;
        logic [2:0][CW-1:0] d2;
        logic [2:0][CW:0]   w;
    } t_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

endpackage

@@ hdl/closest_points_between_lines.sv @@
// Top level: closest points between two 3D lines, fixed point.
//
//  channel   dir  handshake           payload
//  request   in   i_valid / o_stall   i_data : cpl_pkg::t_in  (two lines)
//  result    out  o_valid / i_stall   o_data : cpl_pkg::t_out (t1, t2, dist^2)
//
// One request per cycle sustained while no stall holds the flow. The latency is set
// by the 33-step restoring dividers and the two limb-multiplier chains
// (determinant/numerators and the squares).
// Reset (synchronous, active low) empties the queue and clears all valid flags.
// A held result freezes the back pipeline; the four-entry queue keeps taking
// requests until it fills, then o_stall rises.
module closest_points_between_lines #(
    parameter int FRAC_BITS = cpl_pkg::FRAC_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  cpl_pkg::t_in  i_data,
    output logic          o_stall,
    output logic          o_valid,
    output cpl_pkg::t_out o_data,
    input  logic          i_stall
);
    logic            push, pop;
    cpl_pkg::t_entry f_entry, q_entry;
    cpl_pkg::t_qstat qstat;

    // front: origin difference, queue push
    cpl_front u_front (
        .i_req   (i_data),
        .i_valid (i_valid),
        .i_qstat (qstat),
        .o_push  (push),
        .o_entry (f_entry),
        .o_stall (o_stall)
    );

    // decoupling queue
    cpl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (f_entry),
        .i_pop   (pop),
        .o_entry (q_entry),
        .o_qstat (qstat)
    );

    // back: remaining arithmetic, output register
    cpl_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (q_entry),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

endmodule

@@ hdl/cpl_front.sv @@
// Front end: takes requests, forms the origin difference, pushes the queue.
module cpl_front (
    input  cpl_pkg::t_in    i_req,
    input  logic            i_valid,
    input  cpl_pkg::t_qstat i_qstat,
    output logic            o_push,
    output cpl_pkg::t_entry o_entry,
    output logic            o_stall
);
    localparam int CW = cpl_pkg::CW;

    logic signed [CW:0] s_o1 [3];
    logic signed [CW:0] s_o2 [3];

    always_comb begin
        s_o1[0] = {i_req.line1_origin_x[CW-1], i_req.line1_origin_x};
        s_o1[1] = {i_req.line1_origin_y[CW-1], i_req.line1_origin_y};
        s_o1[2] = {i_req.line1_origin_z[CW-1], i_req.line1_origin_z};
        s_o2[0] = {i_req.line2_origin_x[CW-1], i_req.line2_origin_x};
        s_o2[1] = {i_req.line2_origin_y[CW-1], i_req.line2_origin_y};
        s_o2[2] = {i_req.line2_origin_z[CW-1], i_req.line2_origin_z};
        o_entry.d1[0] = i_req.line1_dir_x;
        o_entry.d1[1] = i_req.line1_dir_y;
        o_entry.d1[2] = i_req.line1_dir_z;
        o_entry.d2[0] = i_req.line2_dir_x;
        o_entry.d2[1] = i_req.line2_dir_y;
        o_entry.d2[2] = i_req.line2_dir_z;
        for (int k = 0; k < 3; k++) begin
            o_entry.w[k] = s_o1[k] - s_o2[k];
        end
    end

    assign o_stall = i_qstat.full;
    assign o_push  = i_valid && !i_qstat.full;

endmodule

@@ hdl/cpl_queue.sv @@
// Small FIFO between front and back.
module cpl_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cpl_pkg::t_entry i_entry,
    input  logic            i_pop,
    output cpl_pkg::t_entry o_entry,
    output cpl_pkg::t_qstat o_qstat
);
    localparam int QD = cpl_pkg::Q_DEPTH;
    localparam int AW = $clog2(QD);

    cpl_pkg::t_entry r_mem [QD];
    logic [AW-1:0]   r_wr, r_rd;
    logic [AW:0]     r_cnt, n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) n_cnt = r_cnt + 1'b1;
        if (!i_push && i_pop) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_entry;
    end

    assign o_entry       = r_mem[r_rd];
    assign o_qstat.empty = (r_cnt == '0);
    assign o_qstat.full  = (r_cnt == (AW+1)'(QD));

endmodule

@@ hdl/cpl_mul.sv @@
// Pipelined signed multiplier built from 32x32 limb products.
module cpl_mul #(
    parameter int AW = 68,
    parameter int BW = 68
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [AW-1:0]     i_a,
    input  logic signed [BW-1:0]     i_b,
    output logic signed [AW+BW-1:0]  o_p
);
    localparam int LW = cpl_pkg::LIMB_W;
    localparam int NA = (AW + LW - 1) / LW;
    localparam int NB = (BW + LW - 1) / LW;
    localparam int PW = AW + BW;
    localparam int SW = (NA + NB) * LW;

    logic [AW-1:0]      s_ma;
    logic [BW-1:0]      s_mb;
    logic [NA*LW-1:0]   r_ma;
    logic [NB*LW-1:0]   r_mb;
    logic [2*LW-1:0]    r_pp [NA*NB];
    logic [SW-1:0]      s_sum;
    logic [PW-1:0]      r_sum;
    logic               r_sg1, r_sg2, r_sg3;
    logic signed [PW-1:0] r_p;

    always_comb begin
        s_ma = i_a[AW-1] ? $unsigned(-i_a) : $unsigned(i_a);
        s_mb = i_b[BW-1] ? $unsigned(-i_b) : $unsigned(i_b);
    end

    always_comb begin
        s_sum = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                s_sum = s_sum + (SW'(r_pp[i*NB+j]) << (LW * (i + j)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma  <= (NA*LW)'(s_ma);
            r_mb  <= (NB*LW)'(s_mb);
            r_sg1 <= i_a[AW-1] ^ i_b[BW-1];
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i*NB+j] <= r_ma[i*LW +: LW] * r_mb[j*LW +: LW];
                end
            end
            r_sg2 <= r_sg1;
            r_sum <= s_sum[PW-1:0];
            r_sg3 <= r_sg2;
            r_p   <= r_sg3 ? $signed(-r_sum) : $signed(r_sum);
        end
    end

    assign o_p = r_p;

endmodule

@@ hdl/cpl_div.sv @@
// Pipelined restoring divider, rounded to nearest and saturated.
module cpl_div #(
    parameter int NW = 137,
    parameter int FB = 16
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [NW-1:0]          i_n,
    input  logic signed [NW-1:0]          i_d,
    output logic signed [cpl_pkg::CW-1:0] o_q
);
    localparam int CW = cpl_pkg::CW;
    localparam int QB = CW + 1;
    localparam int TW = NW + 1 + QB;
    localparam logic [QB-1:0] HI_Q = QB'((64'd1 << (CW - 1)) - 64'd1);
    localparam logic [QB-1:0] LO_Q = QB'(64'd1 << (CW - 1));
    localparam logic signed [CW-1:0] HI = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] LO = {1'b1, {(CW-1){1'b0}}};

    logic [NW-1:0] s_an, s_ad;
    logic [TW-1:0] r_rem [0:QB];
    logic [NW:0]   r_d2  [0:QB];
    logic          r_ng  [0:QB+1];
    logic          r_ov  [1:QB+1];
    logic [QB-1:0] r_q   [1:QB+1];
    logic          s_psat, s_nsat;
    logic signed [CW-1:0] r_res;

    always_comb begin
        s_an = i_n[NW-1] ? $unsigned(-i_n) : $unsigned(i_n);
        s_ad = i_d[NW-1] ? $unsigned(-i_d) : $unsigned(i_d);
    end

    // numerator 2|n|*2^FB + |d| over 2|d|
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= (TW'(s_an) << (FB + 1)) + TW'(s_ad);
            r_d2[0]  <= (NW+1)'(s_ad) << 1;
            r_ng[0]  <= i_n[NW-1] ^ i_d[NW-1];
            r_ov[1]  <= r_rem[0] >= (TW'(r_d2[0]) << QB);
            r_rem[1] <= r_rem[0];
            r_d2[1]  <= r_d2[0];
            r_ng[1]  <= r_ng[0];
            r_q[1]   <= '0;
        end
    end

    for (genvar s = 1; s <= QB; s++) begin : g_bit
        logic [TW-1:0] s_sh;
        logic          s_ge;
        assign s_sh = TW'(r_d2[s]) << (QB - s);
        assign s_ge = r_rem[s] >= s_sh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[s+1]  <= r_q[s] | (QB'(s_ge) << (QB - s));
                r_ov[s+1] <= r_ov[s];
                r_ng[s+1] <= r_ng[s];
            end
        end
        if (s < QB) begin : g_pass
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s+1] <= s_ge ? r_rem[s] - s_sh : r_rem[s];
                    r_d2[s+1]  <= r_d2[s];
                end
            end
        end
    end

    always_comb begin
        s_psat = r_ov[QB+1] || (r_q[QB+1] > HI_Q);
        s_nsat = r_ov[QB+1] || (r_q[QB+1] > LO_Q);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_ng[QB+1]) r_res <= s_nsat ? LO : $signed(-r_q[QB+1][CW-1:0]);
            else            r_res <= s_psat ? HI : $signed(r_q[QB+1][CW-1:0]);
        end
    end

    assign o_q = r_res;

endmodule

@@ hdl/cpl_back.sv @@
// Back end: dot products, determinant, divisions and squared distance.
module cpl_back #(
    parameter int FRAC_BITS = cpl_pkg::FRAC_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cpl_pkg::t_entry i_entry,
    input  cpl_pkg::t_qstat i_qstat,
    output logic            o_pop,
    output logic            o_valid,
    output cpl_pkg::t_out   o_data,
    input  logic            i_stall
);
    localparam int CW    = cpl_pkg::CW;
    localparam int DSW   = cpl_pkg::DIST_W;
    localparam int LD    = cpl_pkg::DIV_LAT;
    localparam int ML    = cpl_pkg::MUL_LAT;
    localparam int PRW   = 2 * CW + 2;
    localparam int DW    = 2 * CW + 4;
    localparam int NW    = 2 * DW + 1;
    localparam int EW    = 2 * CW + 2;
    localparam int SQW   = 2 * EW;
    localparam int SUMW  = SQW + 2;
    localparam int CTX_D = ML + 3 + LD;
    localparam int LAT   = 2 * ML + 6 + LD;
    localparam int TD    = ML + 2;
    localparam int DOT_A = 0;
    localparam int DOT_B = 1;
    localparam int DOT_C = 2;
    localparam int DOT_D = 3;
    localparam int DOT_E = 4;
    localparam logic [NW-1:0] DEN_EPS =
        NW'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100) << (3 * FRAC_BITS);
    localparam logic [SUMW-1:0] HALF = SUMW'(1) << (3 * FRAC_BITS - 1);
    localparam logic [SUMW-1:0] DMAX = SUMW'({DSW{1'b1}});

    logic en;
    logic r_v [1:LAT];
    cpl_pkg::t_entry r_ctx [1:CTX_D];

    logic signed [CW:0]      s_l [5][3];
    logic signed [CW:0]      s_r [5][3];
    logic signed [PRW-1:0]   r_pr [5][3];
    logic signed [DW-1:0]    r_dot [5];
    logic signed [2*DW-1:0]  s_ac, s_bb, s_be, s_cd, s_ae, s_bd;
    logic signed [NW-1:0]    s_den;
    logic signed [NW-1:0]    r_den, r_n1, r_n2;
    logic signed [CW-1:0]    s_t1, s_t2;
    logic signed [2*CW-1:0]  r_m1 [3];
    logic signed [2*CW-1:0]  r_m2 [3];
    logic signed [CW:0]      r_wp [3];
    logic signed [EW-1:0]    r_diff [3];
    logic signed [SQW-1:0]   s_sq [3];
    logic [2*CW-1:0]         r_t [1:TD];
    logic [SUMW-1:0]         s_sum, s_dist;
    cpl_pkg::t_out           r_out;

    // whole pipeline moves together; only a held result stops it
    assign en    = !(r_v[LAT] && i_stall);
    assign o_pop = en && !i_qstat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i <= LAT; i++) r_v[i] <= 1'b0;
        end else if (en) begin
            r_v[1] <= o_pop;
            for (int i = 2; i <= LAT; i++) r_v[i] <= r_v[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctx[1] <= i_entry;
            for (int i = 2; i <= CTX_D; i++) r_ctx[i] <= r_ctx[i-1];
        end
    end

    // dot product operands
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s_l[DOT_A][k] = {i_entry.d1[k][CW-1], i_entry.d1[k]};
            s_r[DOT_A][k] = {i_entry.d1[k][CW-1], i_entry.d1[k]};
            s_l[DOT_B][k] = {i_entry.d1[k][CW-1], i_entry.d1[k]};
            s_r[DOT_B][k] = {i_entry.d2[k][CW-1], i_entry.d2[k]};
            s_l[DOT_C][k] = {i_entry.d2[k][CW-1], i_entry.d2[k]};
            s_r[DOT_C][k] = {i_entry.d2[k][CW-1], i_entry.d2[k]};
            s_l[DOT_D][k] = {i_entry.d1[k][CW-1], i_entry.d1[k]};
            s_r[DOT_D][k] = $signed(i_entry.w[k]);
            s_l[DOT_E][k] = {i_entry.d2[k][CW-1], i_entry.d2[k]};
            s_r[DOT_E][k] = $signed(i_entry.w[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 5; j++) begin
                for (int k = 0; k < 3; k++) r_pr[j][k] <= s_l[j][k] * s_r[j][k];
                r_dot[j] <= DW'(r_pr[j][0]) + DW'(r_pr[j][1]) + DW'(r_pr[j][2]);
            end
        end
    end

    cpl_mul #(.AW(DW), .BW(DW)) u_ac (.i_clk(i_clk), .i_en(en),
        .i_a(r_dot[DOT_A]), .i_b(r_dot[DOT_C]), .o_p(s_ac));
    cpl_mul #(.AW(DW), .BW(DW)) u_bb (.i_clk(i_clk), .i_en(en),
        .i_a(r_dot[DOT_B]), .i_b(r_dot[DOT_B]), .o_p(s_bb));
    cpl_mul #(.AW(DW), .BW(DW)) u_be (.i_clk(i_clk), .i_en(en),
        .i_a(r_dot[DOT_B]), .i_b(r_dot[DOT_E]), .o_p(s_be));
    cpl_mul #(.AW(DW), .BW(DW)) u_cd (.i_clk(i_clk), .i_en(en),
        .i_a(r_dot[DOT_C]), .i_b(r_dot[DOT_D]), .o_p(s_cd));
    cpl_mul #(.AW(DW), .BW(DW)) u_ae (.i_clk(i_clk), .i_en(en),
        .i_a(r_dot[DOT_A]), .i_b(r_dot[DOT_E]), .o_p(s_ae));
    cpl_mul #(.AW(DW), .BW(DW)) u_bd (.i_clk(i_clk), .i_en(en),
        .i_a(r_dot[DOT_B]), .i_b(r_dot[DOT_D]), .o_p(s_bd));

    // parallel or degenerate lines get the small fixed denominator
    assign s_den = NW'(s_ac) - NW'(s_bb);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_den <= (s_den == '0) ? $signed(DEN_EPS) : s_den;
            r_n1  <= NW'(s_be) - NW'(s_cd);
            r_n2  <= NW'(s_ae) - NW'(s_bd);
        end
    end

    cpl_div #(.NW(NW), .FB(FRAC_BITS)) u_div1 (.i_clk(i_clk), .i_en(en),
        .i_n(r_n1), .i_d(r_den), .o_q(s_t1));
    cpl_div #(.NW(NW), .FB(FRAC_BITS)) u_div2 (.i_clk(i_clk), .i_en(en),
        .i_n(r_n2), .i_d(r_den), .o_q(s_t2));

    cpl_mul #(.AW(EW), .BW(EW)) u_sq0 (.i_clk(i_clk), .i_en(en),
        .i_a(r_diff[0]), .i_b(r_diff[0]), .o_p(s_sq[0]));
    cpl_mul #(.AW(EW), .BW(EW)) u_sq1 (.i_clk(i_clk), .i_en(en),
        .i_a(r_diff[1]), .i_b(r_diff[1]), .o_p(s_sq[1]));
    cpl_mul #(.AW(EW), .BW(EW)) u_sq2 (.i_clk(i_clk), .i_en(en),
        .i_a(r_diff[2]), .i_b(r_diff[2]), .o_p(s_sq[2]));

    // closest-point difference uses the saturated parameters
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_m1[k]   <= $signed(r_ctx[CTX_D].d1[k]) * s_t1;
                r_m2[k]   <= $signed(r_ctx[CTX_D].d2[k]) * s_t2;
                r_wp[k]   <= $signed(r_ctx[CTX_D].w[k]);
                r_diff[k] <= (EW'(r_wp[k]) <<< FRAC_BITS) + EW'(r_m1[k]) - EW'(r_m2[k]);
            end
            r_t[1] <= {s_t1, s_t2};
            for (int i = 2; i <= TD; i++) r_t[i] <= r_t[i-1];
        end
    end

    always_comb begin
        s_sum  = SUMW'($unsigned(s_sq[0])) + SUMW'($unsigned(s_sq[1]))
               + SUMW'($unsigned(s_sq[2])) + HALF;
        s_dist = s_sum >> (3 * FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.param_one    <= $signed(r_t[TD][2*CW-1:CW]);
            r_out.param_two    <= $signed(r_t[TD][CW-1:0]);
            r_out.dist_squared <= (s_dist > DMAX) ? {DSW{1'b1}} : s_dist[DSW-1:0];
        end
    end

    assign o_valid = r_v[LAT];
    assign o_data  = r_out;

endmodule

@@ hdl/cpl_checker.sv @@
// Port-level checks for the closest-points block, bound to the top level.
module cpl_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_stall,
    input logic          o_valid,
    input cpl_pkg::t_out o_data,
    input logic          i_stall
);
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_data))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("reset left valid or stall set");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(i_valid))
        else $error("queue filled without a request");

endmodule

bind closest_points_between_lines cpl_checker u_cpl_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .o_data  (o_data),
    .i_stall (i_stall)
);

@@ tb/sv/tb.sv @@
// Testbench for closest_points_between_lines: directed and random line pairs vs. predictor.
`timescale 1ns / 1ps

module tb;

    localparam int CW       = cpl_pkg::CW;
    localparam int DIST_W   = cpl_pkg::DIST_W;
    localparam int FRAC     = cpl_pkg::FRAC_DEF;
    localparam int DRAIN    = 80;      // longer than the pipeline latency
    localparam int WD_LIMIT = 4000;    // idle cycles before the run is declared hung
    localparam int HOLD_LEN = 300;     // long receiver hold-off

    typedef logic signed [255:0] t_wide;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    cpl_pkg::t_in  i_data = '0;
    logic          o_stall;
    logic          o_valid;
    cpl_pkg::t_out o_data;
    logic          i_stall = 1'b0;

    // expected results, oldest first
    cpl_pkg::t_out pending_results[$];
    int    mismatches = 0;
    int    stall_left = 0;
    int    idle_cycles = 0;
    bit    hold_results = 1'b0;   // receiver hold-off, set by the pressure test
    bit    quiet = 1'b0;          // when set, the sender leaves no gaps and the receiver starts no random stalls

    closest_points_between_lines dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_data (i_data),
        .o_stall(o_stall),
        .o_valid(o_valid),
        .o_data (o_data),
        .i_stall(i_stall)
    );

    always #2 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Predictor: exact integer math in 256 bits, rounding only in the
    // two divisions and the final distance scaling.
    // ---------------------------------------------------------------
    function automatic t_wide ext(logic [CW-1:0] v);
        return t_wide'({{(256-CW){v[CW-1]}}, v});
    endfunction

    // signed divide, round to nearest, ties away from zero
    function automatic t_wide div_round(t_wide num, t_wide den);
        logic [255:0] un, ud, q;
        logic         neg;
        neg = num[255] ^ den[255];
        un  = num[255] ? -num : num;
        ud  = den[255] ? -den : den;
        q   = (2 * un + ud) / (2 * ud);
        return neg ? -t_wide'(q) : t_wide'(q);
    endfunction

    function automatic t_wide sat_coord(t_wide v);
        t_wide hi, lo;
        hi = (t_wide'(1) <<< (CW - 1)) - 1;
        lo = -(t_wide'(1) <<< (CW - 1));
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic cpl_pkg::t_out closest_points(cpl_pkg::t_in r);
        t_wide o1[3], d1[3], o2[3], d2[3], w[3];
        t_wide a, b, c, d, e, den, n1, n2, t1, t2, diff, sum, dsq, dmax;
        cpl_pkg::t_out res;
        o1 = '{ext(r.line1_origin_x), ext(r.line1_origin_y), ext(r.line1_origin_z)};
        d1 = '{ext(r.line1_dir_x), ext(r.line1_dir_y), ext(r.line1_dir_z)};
        o2 = '{ext(r.line2_origin_x), ext(r.line2_origin_y), ext(r.line2_origin_z)};
        d2 = '{ext(r.line2_dir_x), ext(r.line2_dir_y), ext(r.line2_dir_z)};
        for (int k = 0; k < 3; k++) w[k] = o1[k] - o2[k];
        a = d1[0]*d1[0] + d1[1]*d1[1] + d1[2]*d1[2];
        b = d1[0]*d2[0] + d1[1]*d2[1] + d1[2]*d2[2];
        c = d2[0]*d2[0] + d2[1]*d2[1] + d2[2]*d2[2];
        d = d1[0]*w[0] + d1[1]*w[1] + d1[2]*w[2];
        e = d2[0]*w[0] + d2[1]*w[1] + d2[2]*w[2];
        den = a*c - b*b;
        // parallel or degenerate directions: fall back to ~0.01
        if (den == 0)
            den = t_wide'(((64'd1 << FRAC) + 50) / 100) <<< (3 * FRAC);
        n1 = b*e - c*d;
        n2 = a*e - b*d;
        t1 = sat_coord(div_round(n1 <<< FRAC, den));
        t2 = sat_coord(div_round(n2 <<< FRAC, den));
        // distance uses the saturated parameters
        sum = 0;
        for (int k = 0; k < 3; k++) begin
            diff = (w[k] <<< FRAC) + d1[k]*t1 - d2[k]*t2;
            sum  = sum + diff*diff;
        end
        dsq  = (sum + (t_wide'(1) <<< (3*FRAC - 1))) >>> (3 * FRAC);
        dmax = (t_wide'(1) <<< DIST_W) - 1;
        if (dsq > dmax) dsq = dmax;
        res.param_one    = t1[CW-1:0];
        res.param_two    = t2[CW-1:0];
        res.dist_squared = dsq[DIST_W-1:0];
        return res;
    endfunction

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // ---------------------------------------------------------------
    // Sender: one request, held until accepted, then an optional gap.
    // Called at a rising edge; returns at a rising edge.
    // ---------------------------------------------------------------
    task automatic send_request(cpl_pkg::t_in r);
        int gap;
        i_valid <= 1'b1;
        i_data  <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(closest_points(r));
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_results_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [CW-1:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1: return $urandom;
            2: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            3: return $signed($urandom_range(0, 32'h0000_0100)) - 32'sh0000_0080;
            default: return $urandom;
        endcase
    endfunction

    function automatic cpl_pkg::t_in rnd_request();
        cpl_pkg::t_in r;
        int    kind;
        logic signed [CW-1:0] s;
        r = {rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
             rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()};
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            // parallel: second direction a small multiple of the first
            s = $signed($urandom_range(0, 6)) - 3;
            r.line1_dir_x = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
            r.line1_dir_y = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
            r.line1_dir_z = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
            r.line2_dir_x = r.line1_dir_x * s;
            r.line2_dir_y = r.line1_dir_y * s;
            r.line2_dir_z = r.line1_dir_z * s;
        end else if (kind == 1) begin
            // zero-length direction on one line
            if ($urandom_range(0, 1)) {r.line1_dir_x, r.line1_dir_y, r.line1_dir_z} = '0;
            else                      {r.line2_dir_x, r.line2_dir_y, r.line2_dir_z} = '0;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_extremes();
        cpl_pkg::t_in r;
        r = '0;                        send_request(r);
        r = {12{32'h7FFF_FFFF}};       send_request(r);
        r = {12{32'h8000_0000}};       send_request(r);
        r = {12{32'hFFFF_FFFF}};       send_request(r);
        r = {{6{32'h7FFF_FFFF}}, {6{32'h8000_0000}}};  send_request(r);
        r = {{3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}, {3{32'h8000_0000}},
             {3{32'h7FFF_FFFF}}};      send_request(r);
        r = {12{32'h5555_5555}};       send_request(r);
        r = {12{32'hAAAA_AAAA}};       send_request(r);
        // far-apart points with no direction: distance saturates
        r = '0;
        r.line1_origin_x = 32'h7FFF_FFFF; r.line1_origin_y = 32'h7FFF_FFFF;
        r.line1_origin_z = 32'h7FFF_FFFF; r.line2_origin_x = 32'h8000_0000;
        r.line2_origin_y = 32'h8000_0000; r.line2_origin_z = 32'h8000_0000;
        send_request(r);
    endtask

    task automatic test_geometry();
        cpl_pkg::t_in r;
        // skew perpendicular unit lines, one unit apart in z
        r = '0;
        r.line1_dir_x = 32'h0001_0000;
        r.line2_dir_y = 32'h0001_0000;
        r.line2_origin_z = 32'h0001_0000;
        r.line2_origin_x = 32'h0003_0000;
        send_request(r);
        // intersecting lines
        r = '0;
        r.line1_origin_x = 32'hFFFE_0000; r.line1_dir_x = 32'h0001_0000;
        r.line2_origin_y = 32'h0002_8000; r.line2_dir_y = 32'hFFFF_0000;
        send_request(r);
        // parallel lines: zero denominator path
        r = '0;
        r.line1_dir_x = 32'h0001_0000; r.line2_dir_x = 32'h0002_0000;
        r.line2_origin_y = 32'h0005_0000;
        send_request(r);
        // both directions zero
        r = '0;
        r.line1_origin_x = 32'h0000_0001; r.line2_origin_z = 32'hFFFF_FFFF;
        send_request(r);
        // nearly parallel: huge parameters saturate both ways
        r = '0;
        r.line1_dir_x = 32'h0001_0000; r.line2_dir_x = 32'h0001_0000;
        r.line2_dir_y = 32'h0000_0001; r.line2_origin_y = 32'h7000_0000;
        send_request(r);
        r.line2_origin_y = 32'h9000_0000;
        send_request(r);
        // tiny fractions exercise rounding
        r = {12{32'h0000_0001}};
        r.line2_dir_z = 32'hFFFF_FFFF; r.line1_origin_y = 32'h0000_0003;
        send_request(r);
        for (int k = 0; k < 6; k++) send_request(rnd_request());
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_backpressure();
        quiet = 1'b1;
        fork
            begin
                hold_results = 1'b1;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_results = 1'b0;
            end
            for (int k = 0; k < 80; k++) send_request(rnd_request());
        join
        quiet = 1'b0;
    endtask

    // sender pauses until the pipeline is empty, then resumes
    task automatic test_drain_pause();
        for (int k = 0; k < 20; k++) send_request(rnd_request());
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait_results_drained();
        for (int k = 0; k < 20; k++) send_request(rnd_request());
    endtask

    task automatic test_random(int count);
        for (int k = 0; k < count; k++) begin
            // alternate stretches with and without idling
            if (k % 200 == 0) quiet = ($urandom_range(0, 2) == 0);
            send_request(rnd_request());
        end
        quiet = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Result side: random stalls plus the hold-off, and checking
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result t1=%h t2=%h d2=%h",
                                 o_data.param_one, o_data.param_two, o_data.dist_squared);
                end else begin
                    cpl_pkg::t_out exp_r;
                    exp_r = pending_results.pop_front();
                    if (o_data.param_one !== exp_r.param_one ||
                        o_data.param_two !== exp_r.param_two ||
                        o_data.dist_squared !== exp_r.dist_squared) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: t1 %h/%h t2 %h/%h d2 %h/%h (exp/got)",
                                     exp_r.param_one, o_data.param_one,
                                     exp_r.param_two, o_data.param_two,
                                     exp_r.dist_squared, o_data.dist_squared);
                    end
                end
            end
        end
        if (hold_results) begin
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 99) < 30) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                      : $urandom_range(0, 2);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // watchdog: cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WD_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_geometry();
        test_backpressure();
        test_drain_pause();
        test_random(1360);
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait_results_drained();
        repeat (DRAIN) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
